/* hw/rtl/lrci_pkg.sv */
// Shared types and constants for the line rasterizer with color interpolation.
// Used by lrci_ctrl, lrci_dpath and line_raster_color_interp_top.
`default_nettype none
package lrci_pkg;

  // Default coordinate width and the pixel limit per line
  localparam int COORD_BITS_DEF = 6;
  localparam int MAX_PIXELS     = 64;
  localparam int PIX_CNT_W      = $clog2(MAX_PIXELS + 1);

  // Output packing: x, y, red, green, blue, alpha
  localparam int OUT_COORD_W = 6;
  localparam int CHAN_W      = 8;
  localparam int OUT_W       = ((2 * OUT_COORD_W + 4 * CHAN_W + 7) / 8) * 8;

  // Iteration counts of the shared divider and square root units
  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 16;
  localparam int ITER_W     = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic setup;
    logic prep;
    logic pinit;
    logic chk;
    logic div_step;
    logic sq_init;
    logic sq_step;
    logic mix;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic direct;    // weight settled without divide and square root
    logic last;      // current pixel is the final one of the line
    logic out_free;  // output register can take a new item
  } sts_t;

endpackage
`default_nettype wire

/* hw/rtl/lrci_ctrl.sv */
// Controller state machine of the line rasterizer: sequences setup, the
// per-pixel divide / square root / mix steps. Depends on lrci_pkg.
`default_nettype none
module lrci_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire lrci_pkg::sts_t sts,
  output lrci_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SETUP  = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_PINIT  = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_SQINIT = 4'd6;
  localparam logic [3:0] S_SQRT   = 4'd7;
  localparam logic [3:0] S_MIX    = 4'd8;

  localparam logic [lrci_pkg::ITER_W-1:0] DIV_LAST =
    lrci_pkg::ITER_W'(lrci_pkg::DIV_STEPS - 1);
  localparam logic [lrci_pkg::ITER_W-1:0] SQRT_LAST =
    lrci_pkg::ITER_W'(lrci_pkg::SQRT_STEPS - 1);

  logic [3:0]                   state_r, state_nxt;
  logic [lrci_pkg::ITER_W-1:0]  cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_PINIT;
      end
      S_PINIT: begin
        cmd.pinit = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        cnt_nxt = '0;
        state_nxt = sts.direct ? S_MIX : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_SQINIT;
        end
      end
      S_SQINIT: begin
        cmd.sq_init = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == SQRT_LAST) begin
          state_nxt = S_MIX;
        end
      end
      S_MIX: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.mix   = 1'b1;
          state_nxt = sts.last ? S_IDLE : S_PINIT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lrci_dpath.sv */
// Datapath of the line rasterizer: endpoint ordering, Bresenham stepping,
// restoring divider, square root unit, color mix, output register.
// Depends on lrci_pkg.
`default_nettype none
module lrci_dpath #(
  parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire lrci_pkg::cmd_t                              cmd,
  output lrci_pkg::sts_t                                   sts,
  input  wire logic [((4*COORD_BITS+64+7)/8)*8-1:0]        in_tdata,
  output logic                                             out_tvalid,
  input  wire logic                                        out_tready,
  output logic [lrci_pkg::OUT_W-1:0]                       out_tdata,
  output logic                                             out_tlast
);

  localparam int C  = COORD_BITS;
  localparam int D  = 2 * C + 1;   // squared distance width
  localparam int DW = C + 3;       // decision variable width
  localparam int KW = lrci_pkg::PIX_CNT_W;
  localparam int CB = 4 * C;       // color field base in tdata

  // Raw item
  logic [C-1:0] ax_r, ay_r, bx_r, by_r;
  logic [7:0]   ca_r [4];
  logic [7:0]   cb_r [4];

  // Ordered endpoints
  logic [C-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [7:0]   c0_r [4];
  logic [7:0]   c1_r [4];
  logic         xmajor_r;

  // Line constants and stepping state
  logic [D-1:0]        dl2_r;
  logic [C-1:0]        amin_r, major_r;
  logic                step_neg_r;
  logic signed [DW-1:0] dec_r;
  logic [KW-1:0]       n_r, k_r;
  logic [C-1:0]        px_r, py_r;

  // Weight computation
  logic [D-1:0]  dp2_r;
  logic [D-1:0]  rem_r;
  logic [31:0]   q_r;
  logic [31:0]   v_r;
  logic [32:0]   res_r;
  logic [31:0]   bit_r;
  logic [16:0]   w_r;

  // Output register
  logic                     out_valid_r;
  logic [lrci_pkg::OUT_W-1:0] out_data_r;
  logic                     out_last_r;

  // Setup terms
  logic [C-1:0] adx, ady;
  logic         xmajor, swap;
  always_comb begin
    adx    = (bx_r >= ax_r) ? bx_r - ax_r : ax_r - bx_r;
    ady    = (by_r >= ay_r) ? by_r - ay_r : ay_r - by_r;
    xmajor = ady < adx;
    swap   = xmajor ? (bx_r < ax_r) : (by_r < ay_r);
  end

  // Prep terms
  logic [C-1:0]  ldx, ldy, pmajor, pmin, pminc_s, pminc_e;
  logic [C:0]    total;
  logic [D-1:0]  dl2;
  always_comb begin
    ldx     = (ex_r >= sx_r) ? ex_r - sx_r : sx_r - ex_r;
    ldy     = (ey_r >= sy_r) ? ey_r - sy_r : sy_r - ey_r;
    dl2     = D'({C'(0), ldx} * {C'(0), ldx}) + D'({C'(0), ldy} * {C'(0), ldy});
    pmajor  = xmajor_r ? ldx : ldy;
    pmin    = xmajor_r ? ldy : ldx;
    pminc_s = xmajor_r ? sy_r : sx_r;
    pminc_e = xmajor_r ? ey_r : ex_r;
    total   = {1'b0, pmajor} + (C+1)'(1);
  end

  // Distance of the current pixel from the start
  logic [C-1:0] ddx, ddy;
  logic [D-1:0] dp2;
  always_comb begin
    ddx = (px_r >= sx_r) ? px_r - sx_r : sx_r - px_r;
    ddy = (py_r >= sy_r) ? py_r - sy_r : sy_r - py_r;
    dp2 = D'({C'(0), ddx} * {C'(0), ddx}) + D'({C'(0), ddy} * {C'(0), ddy});
  end

  // Divider and square root steps
  logic [D:0]  rem_sh;
  logic        rem_ge;
  logic [32:0] sq_t;
  logic        sq_ge;
  always_comb begin
    rem_sh = {rem_r, 1'b0};
    rem_ge = rem_sh >= {1'b0, dl2_r};
    sq_t   = res_r + {1'b0, bit_r};
    sq_ge  = {1'b0, v_r} >= sq_t;
  end

  // Color mix
  logic [16:0] iw;
  logic [25:0] acc [4];
  always_comb begin
    iw = 17'h10000 - w_r;
    for (int i = 0; i < 4; i++) begin
      acc[i] = 26'(c0_r[i]) * 26'(iw) + 26'(c1_r[i]) * 26'(w_r);
    end
  end

  assign sts.direct   = (dl2_r == '0) || (dp2_r >= dl2_r);
  assign sts.last     = (k_r == n_r - 1'b1);
  assign sts.out_free = !out_valid_r || out_tready;

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= in_tdata[C-1:0];
      ay_r <= in_tdata[2*C-1:C];
      bx_r <= in_tdata[3*C-1:2*C];
      by_r <= in_tdata[4*C-1:3*C];
      for (int i = 0; i < 4; i++) begin
        ca_r[i] <= in_tdata[CB + 8*i +: 8];
        cb_r[i] <= in_tdata[CB + 32 + 8*i +: 8];
      end
    end
    // order endpoints along the major axis
    if (cmd.setup) begin
      xmajor_r <= xmajor;
      sx_r <= swap ? bx_r : ax_r;
      sy_r <= swap ? by_r : ay_r;
      ex_r <= swap ? ax_r : bx_r;
      ey_r <= swap ? ay_r : by_r;
      for (int i = 0; i < 4; i++) begin
        c0_r[i] <= swap ? cb_r[i] : ca_r[i];
        c1_r[i] <= swap ? ca_r[i] : cb_r[i];
      end
    end
    // line constants and the first pixel
    if (cmd.prep) begin
      dl2_r      <= dl2;
      major_r    <= pmajor;
      amin_r     <= pmin;
      step_neg_r <= pminc_e < pminc_s;
      dec_r      <= $signed({2'b0, pmin, 1'b0}) - $signed({3'b0, pmajor});
      n_r        <= (32'(total) > 32'(lrci_pkg::MAX_PIXELS)) ?
                    KW'(lrci_pkg::MAX_PIXELS) : KW'(total);
      k_r        <= '0;
      px_r       <= sx_r;
      py_r       <= sy_r;
    end
    if (cmd.pinit) begin
      dp2_r <= dp2;
    end
    // settle trivial weights or start the divide
    if (cmd.chk) begin
      rem_r <= dp2_r;
      q_r   <= '0;
      w_r   <= (dl2_r == '0) ? 17'd0 : 17'h10000;
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? D'(rem_sh - {1'b0, dl2_r}) : rem_sh[D-1:0];
      q_r   <= {q_r[30:0], rem_ge};
    end
    if (cmd.sq_init) begin
      v_r   <= q_r;
      res_r <= '0;
      bit_r <= 32'h4000_0000;
    end
    if (cmd.sq_step) begin
      if (sq_ge) begin
        v_r   <= 32'({1'b0, v_r} - sq_t);
        res_r <= (res_r >> 1) + {1'b0, bit_r};
        w_r   <= 17'((res_r >> 1) + {1'b0, bit_r});
      end else begin
        res_r <= res_r >> 1;
        w_r   <= 17'(res_r >> 1);
      end
      bit_r <= bit_r >> 2;
    end
    // emit the pixel and advance Bresenham
    if (cmd.mix) begin
      out_data_r <= lrci_pkg::OUT_W'({acc[3][23:16], acc[2][23:16], acc[1][23:16],
                                       acc[0][23:16], 6'(py_r), 6'(px_r)});
      out_last_r <= sts.last;
      k_r        <= k_r + 1'b1;
      if (dec_r > 0) begin
        dec_r <= dec_r + $signed({2'b0, amin_r, 1'b0}) - $signed({2'b0, major_r, 1'b0});
        if (xmajor_r) begin
          px_r <= px_r + 1'b1;
          py_r <= step_neg_r ? py_r - 1'b1 : py_r + 1'b1;
        end else begin
          py_r <= py_r + 1'b1;
          px_r <= step_neg_r ? px_r - 1'b1 : px_r + 1'b1;
        end
      end else begin
        dec_r <= dec_r + $signed({2'b0, amin_r, 1'b0});
        if (xmajor_r) begin
          px_r <= px_r + 1'b1;
        end else begin
          py_r <= py_r + 1'b1;
        end
      end
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.mix) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

/* hw/rtl/line_raster_color_interp_top.sv */
// Top level of the line rasterizer with color interpolation.
// Per line: load, setup, prep; per pixel: pinit, chk, then a 32-step divider and
// 16-step square root unit unless the weight is 0 or 1, then mix, which stalls
// while the output register is full. A new line is taken only after the last pixel.
// Reset (rst_n, synchronous, active low) clears the controller and out_tvalid.
// Depends on lrci_pkg, lrci_ctrl, lrci_dpath.
`default_nettype none
module line_raster_color_interp_top #(
  parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // start_x, start_y, end_x, end_y (COORD_BITS each), start_red, start_green,
  // start_blue, start_alpha, end_red, end_green, end_blue, end_alpha (8 each)
  input  wire logic [((4*COORD_BITS+64+7)/8)*8-1:0] in_tdata,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // out_x, out_y (6 each), out_red, out_green, out_blue, out_alpha (8 each)
  output logic [lrci_pkg::OUT_W-1:0]                out_tdata,
  output logic                                      out_tlast,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready
);

  lrci_pkg::cmd_t cmd;
  lrci_pkg::sts_t sts;

  lrci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrci_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* sim/line_raster_color_interp_top_tb.sv */
// Testbench for line_raster_color_interp_top: drives lines on the input stream,
// predicts every pixel with its coordinates, color and last flag, and checks them.
// Depends on lrci_pkg and the line_raster_color_interp_top RTL.
`timescale 1ns / 100ps
`default_nettype none
module line_raster_color_interp_top_tb;

  localparam int CB   = 6;
  localparam int IN_W = ((4*CB+64+7)/8)*8;
  localparam int LIMIT = 10000000;

  typedef struct packed {
    logic [5:0] x;
    logic [5:0] y;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pixel_t;

  logic clk = 0, rst_n = 0;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tvalid = 0, in_tready;
  logic [lrci_pkg::OUT_W-1:0] out_tdata;
  logic out_tlast, out_tvalid;
  logic out_tready = 0;
  logic in_tready_s = 0;

  logic [IN_W-1:0] line_q[$];
  pixel_t pixel_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet_phase = 0;
  bit hold_in = 0;
  int in_gap = 0, out_gap = 0;

  line_raster_color_interp_top #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Integer square root of a 64-bit value
  function automatic logic [31:0] isqrt(input logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res[31:0];
  endfunction

  // Rasterize one line into the expected pixel queue
  task automatic rasterize_line(input logic [IN_W-1:0] d);
    int ax, ay, bx, by, sx, sy, ex, ey, dx, dy, adx, ady;
    int major, minor, minc, dec, stp, amin, n, k, px, py, i;
    bit xmaj;
    logic [7:0] ca[4], cb[4], c0[4], c1[4];
    logic [63:0] dl2, dp2, rat;
    logic [31:0] w, iw;
    pixel_t p;
    logic [7:0] ch[4];
    ax = d[5:0]; ay = d[11:6]; bx = d[17:12]; by = d[23:18];
    for (i = 0; i < 4; i++) begin
      ca[i] = d[24+8*i +: 8];
      cb[i] = d[56+8*i +: 8];
    end
    adx = bx - ax; if (adx < 0) adx = -adx;
    ady = by - ay; if (ady < 0) ady = -ady;
    xmaj = ady < adx;
    if ((xmaj && bx < ax) || (!xmaj && by < ay)) begin
      sx = bx; sy = by; ex = ax; ey = ay; c0 = cb; c1 = ca;
    end else begin
      sx = ax; sy = ay; ex = bx; ey = by; c0 = ca; c1 = cb;
    end
    dx = ex - sx; dy = ey - sy;
    dl2 = 64'(dx*dx + dy*dy);
    if (xmaj) begin
      major = dx; minor = dy; minc = sy;
    end else begin
      major = dy; minor = dx; minc = sx;
    end
    stp = 1; amin = minor;
    if (amin < 0) begin stp = -1; amin = -amin; end
    dec = 2*amin - major;
    n = major + 1;
    if (n > lrci_pkg::MAX_PIXELS) n = lrci_pkg::MAX_PIXELS;
    for (k = 0; k < n; k++) begin
      if (xmaj) begin px = sx + k; py = minc; end
      else begin px = minc; py = sy + k; end
      dp2 = 64'((px-sx)*(px-sx) + (py-sy)*(py-sy));
      if (dl2 == 0) w = 0;
      else if (dp2 >= dl2) w = 65536;
      else begin
        rat = (dp2 << 32) / dl2;
        w = isqrt(rat);
      end
      iw = 65536 - w;
      for (i = 0; i < 4; i++) begin
        logic [63:0] m;
        m = 64'(c0[i]) * 64'(iw) + 64'(c1[i]) * 64'(w);
        ch[i] = m[23:16];
      end
      p.x = px[5:0]; p.y = py[5:0];
      p.r = ch[0]; p.g = ch[1]; p.b = ch[2]; p.a = ch[3];
      p.last = (k == n-1);
      pixel_q.push_back(p);
      if (dec > 0) begin
        minc += stp; dec += 2*(amin - major);
      end else begin
        dec += 2*amin;
      end
    end
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [IN_W-1:0] pack_line(input int ax, ay, bx, by,
                                                input logic [31:0] cs, ce);
    logic [IN_W-1:0] d;
    d = '0;
    d[5:0] = 6'(ax); d[11:6] = 6'(ay); d[17:12] = 6'(bx); d[23:18] = 6'(by);
    d[55:24] = cs; d[87:56] = ce;
    return d;
  endfunction

  // Drive input items at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready_s) begin
        rasterize_line(in_tdata);
      end
      if (!in_tvalid || in_tready_s) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 0;
        end else if (hold_in || line_q.size() == 0) begin
          in_tvalid <= 0;
        end else begin
          in_tdata <= line_q.pop_front();
          in_tvalid <= 1;
          if (!quiet_phase && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 10);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if (!quiet_phase && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 10);
      end
    end
  end

  // Sample handshakes at the rising edge
  always @(posedge clk) begin
    pixel_t e;
    cycles++;
    in_tready_s <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pixel_q.size() == 0) begin
          report("unexpected pixel", 0, 0);
        end else begin
          e = pixel_q.pop_front();
          if (out_tdata[5:0] != e.x) report("x", out_tdata[5:0], e.x);
          if (out_tdata[11:6] != e.y) report("y", out_tdata[11:6], e.y);
          if (out_tdata[19:12] != e.r) report("red", out_tdata[19:12], e.r);
          if (out_tdata[27:20] != e.g) report("green", out_tdata[27:20], e.g);
          if (out_tdata[35:28] != e.b) report("blue", out_tdata[35:28], e.b);
          if (out_tdata[43:36] != e.a) report("alpha", out_tdata[43:36], e.a);
          if (out_tlast != e.last) report("last", out_tlast, e.last);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Wait until the input queue drains and every pixel has come back
  task automatic drain();
    while (line_q.size() != 0 || in_tvalid || in_tready_s) @(posedge clk);
    repeat (2) @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 63;
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  initial begin
    int i, ax, ay, len;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // Directed: coincident points, axis-aligned, diagonals, extremes, far pixels
    line_q.push_back(pack_line(0, 0, 0, 0, 32'h04030201, 32'hFFFFFFFF));
    line_q.push_back(pack_line(63, 63, 63, 63, 32'hFFFFFFFF, 32'h0));
    line_q.push_back(pack_line(0, 0, 63, 0, 32'h0, 32'hFFFFFFFF));
    line_q.push_back(pack_line(63, 0, 0, 0, 32'hFFFFFFFF, 32'h0));
    line_q.push_back(pack_line(0, 0, 0, 63, 32'hFF00FF00, 32'h00FF00FF));
    line_q.push_back(pack_line(0, 63, 0, 0, 32'h12345678, 32'h87654321));
    line_q.push_back(pack_line(0, 0, 63, 63, 32'hFFFFFFFF, 32'h0));
    line_q.push_back(pack_line(63, 0, 0, 63, 32'h0, 32'hFFFFFFFF));
    line_q.push_back(pack_line(10, 20, 15, 22, 32'hAA55AA55, 32'h55AA55AA));
    line_q.push_back(pack_line(15, 22, 10, 20, 32'hAA55AA55, 32'h55AA55AA));
    line_q.push_back(pack_line(5, 5, 7, 12, 32'h80808080, 32'h7F7F7F7F));
    line_q.push_back(pack_line(7, 12, 5, 5, 32'h01020304, 32'hFEFDFCFB));
    line_q.push_back(pack_line(30, 30, 31, 31, 32'hFFFFFFFF, 32'h0));
    line_q.push_back(pack_line(30, 30, 33, 31, 32'h0, 32'hFFFFFFFF));
    line_q.push_back(pack_line(0, 63, 63, 62, 32'h0, 32'hFFFFFFFF));
    drain();
    // Hold the sender while two lines are queued, then resume
    hold_in = 1;
    line_q.push_back(pack_line(1, 2, 9, 4, $urandom, $urandom));
    line_q.push_back(pack_line(2, 9, 4, 1, $urandom, $urandom));
    repeat (20) @(posedge clk);
    hold_in = 0;
    drain();
    // Random lines: mostly short, a few long
    for (i = 0; i < 345; i++) begin
      if (i == 300) begin
        drain();
        quiet_phase = 1;
      end
      if ($urandom_range(0, 9) == 0) begin
        line_q.push_back(pack_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                   $urandom, $urandom));
      end else begin
        ax = $urandom_range(0, 63); ay = $urandom_range(0, 63);
        len = $urandom_range(0, 4);
        line_q.push_back(pack_line(ax, ay,
          ($urandom_range(0, 1) ? ax + len : ax - len) & 63,
          ($urandom_range(0, 1) ? ay + $urandom_range(0, 4) : ay - $urandom_range(0, 4)) & 63,
          $urandom, $urandom));
      end
      if (line_q.size() > 8) drain();
    end
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/lrci_pkg.sv
hw/rtl/lrci_ctrl.sv
hw/rtl/lrci_dpath.sv
hw/rtl/line_raster_color_interp_top.sv
sim/line_raster_color_interp_top_tb.sv
